// ===== src/bsdp_pkg.sv =====
// shared types and constants of the bitmap segment descriptor parser
package bsdp_pkg;

   localparam int MaxDescriptors = 4096;
   localparam int MaxExtBytes    = 4;

   localparam int SegCountFieldMax  = 8191;
   localparam int SegLenFieldMax    = 131071;
   localparam int DescLenFieldMax   = 32767;

   localparam int SegCountLimitInt  = (MaxDescriptors < SegCountFieldMax) ?
                                      MaxDescriptors : SegCountFieldMax;
   localparam int SegLenLimitInt    = (MaxDescriptors * 16 < SegLenFieldMax) ?
                                      MaxDescriptors * 16 : SegLenFieldMax;
   localparam int DescLenLimitInt   = (MaxDescriptors * (1 + MaxExtBytes) < DescLenFieldMax) ?
                                      MaxDescriptors * (1 + MaxExtBytes) : DescLenFieldMax;

   localparam logic [12:0] SegCountLimit = 13'(SegCountLimitInt);
   localparam logic [16:0] SegLenLimit   = 17'(SegLenLimitInt);
   localparam logic [14:0] DescLenLimit  = 15'(DescLenLimitInt);

   localparam logic [2:0] ExtBytesMax  = 3'(MaxExtBytes);
   localparam logic [3:0] CompactReset = 4'd12;
   localparam logic [7:0] ByteMax      = 8'hff;

   localparam int QueueDepth    = 2;
   localparam int QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [4:0]  seg_bytes;
      logic [31:0] zero_bytes;
      logic        truncated;
      logic        end_of_stream;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/bsdp_if.sv =====
// request and response channel interfaces of the descriptor parser
interface bsdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] desc_byte;
   logic       last_byte;

   modport source (output valid, output desc_byte, output last_byte, input ready);
   modport sink   (input valid, input desc_byte, input last_byte, output ready);
endinterface

interface bsdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  seg_bytes;
   logic [31:0] zero_bytes;
   logic [2:0]  zero_space;
   logic [12:0] segment_count;
   logic [16:0] total_seg_length;
   logic [14:0] canonical_desc_length;
   logic        truncated;
   logic        end_of_stream;

   modport source (output valid, output seg_bytes, output zero_bytes, output zero_space,
                   output segment_count, output total_seg_length,
                   output canonical_desc_length, output truncated, output end_of_stream,
                   input ready);
   modport sink   (input valid, input seg_bytes, input zero_bytes, input zero_space,
                   input segment_count, input total_seg_length,
                   input canonical_desc_length, input truncated, input end_of_stream,
                   output ready);
endinterface

// ===== src/bsdp_front.sv =====
// byte parser: header split and little-endian extension accumulation
module bsdp_front
   import bsdp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [3:0]       compact,
   bsdp_req_if.sink         req_if,
   input  queue_status_type q_status,
   output logic             push,
   output desc_type         push_desc
);

   logic [2:0]  ext_rem_ff, ext_rem_in;
   logic [1:0]  shift_idx_ff, shift_idx_in;
   logic [4:0]  seg_len_ff, seg_len_in;
   logic [31:0] zero_acc_ff, zero_acc_in;
   logic        accept;
   logic        done;
   logic [3:0]  code;
   logic [3:0]  n_ext;

   assign req_if.ready = !q_status.full;
   assign accept       = req_if.valid && req_if.ready;
   assign code         = req_if.desc_byte[3:0];
   assign n_ext        = 4'(code - compact);

   always_comb begin
      ext_rem_in   = ext_rem_ff;
      shift_idx_in = shift_idx_ff;
      seg_len_in   = seg_len_ff;
      zero_acc_in  = zero_acc_ff;
      done         = 1'b0;
      if (ext_rem_ff == 3'd0) begin
         seg_len_in   = 5'(req_if.desc_byte[7:4]) + 5'd1;
         shift_idx_in = 2'd0;
         if (code <= compact) begin
            zero_acc_in = 32'(code);
            done        = 1'b1;
         end else begin
            zero_acc_in = 32'd0;
            ext_rem_in  = (n_ext > 4'(ExtBytesMax)) ? ExtBytesMax : n_ext[2:0];
         end
      end else begin
         zero_acc_in  = zero_acc_ff | (32'(req_if.desc_byte) << {shift_idx_ff, 3'b000});
         shift_idx_in = shift_idx_ff + 2'd1;
         ext_rem_in   = ext_rem_ff - 3'd1;
         done         = (ext_rem_ff == 3'd1);
      end
   end

   assign push                    = accept && (done || req_if.last_byte);
   assign push_desc.seg_bytes     = seg_len_in;
   assign push_desc.zero_bytes    = zero_acc_in;
   assign push_desc.truncated     = !done && req_if.last_byte;
   assign push_desc.end_of_stream = req_if.last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_rem_ff   <= 3'd0;
         shift_idx_ff <= 2'd0;
         seg_len_ff   <= 5'd0;
         zero_acc_ff  <= 32'd0;
      end else if (accept) begin
         if (req_if.last_byte) begin
            ext_rem_ff   <= 3'd0;
            shift_idx_ff <= 2'd0;
            seg_len_ff   <= 5'd0;
            zero_acc_ff  <= 32'd0;
         end else begin
            ext_rem_ff   <= ext_rem_in;
            shift_idx_ff <= shift_idx_in;
            seg_len_ff   <= seg_len_in;
            zero_acc_ff  <= zero_acc_in;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ext_rem_ff <= ExtBytesMax)
      else $error("extension count above limit");

   assert property (@(posedge clock) disable iff (reset)
      accept && req_if.last_byte |=> ext_rem_ff == 3'd0 && zero_acc_ff == 32'd0)
      else $error("parser state not cleared after end of stream");

   assert property (@(posedge clock) disable iff (reset)
      push && push_desc.truncated |-> push_desc.end_of_stream)
      else $error("truncated descriptor without end of stream");

endmodule

// ===== src/bsdp_queue.sv =====
// short descriptor queue between parser and accumulator
module bsdp_queue
   import bsdp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  desc_type         push_desc,
   input  logic             pop,
   output desc_type         head_desc,
   output queue_status_type q_status
);

   desc_type                   entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntWidth-1:0]   count_ff;

   assign head_desc      = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QueueCntWidth'(QueueDepth));
   assign q_status.empty = (count_ff == '0);

   function automatic logic [QueuePtrWidth-1:0] next_ptr(input logic [QueuePtrWidth-1:0] p);
      next_ptr = (p == QueuePtrWidth'(QueueDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("transfer into full queue");

   assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntWidth'(QueueDepth))
      else $error("queue count overflow");

endmodule

// ===== src/bsdp_back.sv =====
// accumulator: canonical size, saturating totals and response register
module bsdp_back
   import bsdp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [3:0]       compact,
   input  desc_type         head_desc,
   input  queue_status_type q_status,
   output logic             pop,
   bsdp_rsp_if.source       rsp_if
);

   logic        rsp_valid_ff;
   logic [4:0]  seg_ff;
   logic [31:0] zero_ff;
   logic [2:0]  space_ff, space;
   logic        trunc_ff, eos_ff;
   logic [12:0] cnt_ff, cnt_new;
   logic [16:0] seg_sum_ff, seg_sum_new;
   logic [14:0] desc_sum_ff, desc_sum_new;
   logic [17:0] seg_sum_wide;
   logic [15:0] desc_sum_wide;
   logic        complete;

   assign pop      = !q_status.empty && (!rsp_valid_ff || rsp_if.ready);
   assign complete = !head_desc.truncated;

   always_comb begin
      space = 3'd0;
      if (complete && (head_desc.zero_bytes > 32'(compact))) begin
         priority if (head_desc.zero_bytes[31:24] != 8'd0) begin
            space = 3'd4;
         end else if (head_desc.zero_bytes[23:16] != 8'd0) begin
            space = 3'd3;
         end else if (head_desc.zero_bytes[15:8] != 8'd0) begin
            space = 3'd2;
         end else begin
            space = 3'd1;
         end
      end
   end

   assign seg_sum_wide  = 18'(seg_sum_ff) + 18'(head_desc.seg_bytes);
   assign desc_sum_wide = 16'(desc_sum_ff) + 16'(space) + 16'd1;

   always_comb begin
      cnt_new      = cnt_ff;
      seg_sum_new  = seg_sum_ff;
      desc_sum_new = desc_sum_ff;
      if (complete) begin
         cnt_new      = (cnt_ff >= SegCountLimit) ? SegCountLimit : cnt_ff + 13'd1;
         seg_sum_new  = (seg_sum_wide > 18'(SegLenLimit)) ? SegLenLimit : seg_sum_wide[16:0];
         desc_sum_new = (desc_sum_wide > 16'(DescLenLimit)) ? DescLenLimit :
                        desc_sum_wide[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 13'd0;
         seg_sum_ff   <= 17'd0;
         desc_sum_ff  <= 15'd0;
      end else begin
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop) begin
            if (head_desc.end_of_stream) begin
               cnt_ff      <= 13'd0;
               seg_sum_ff  <= 17'd0;
               desc_sum_ff <= 15'd0;
            end else begin
               cnt_ff      <= cnt_new;
               seg_sum_ff  <= seg_sum_new;
               desc_sum_ff <= desc_sum_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         seg_ff   <= head_desc.seg_bytes;
         zero_ff  <= head_desc.zero_bytes;
         space_ff <= space;
         trunc_ff <= head_desc.truncated;
         eos_ff   <= head_desc.end_of_stream;
      end
   end

   logic [12:0] rsp_cnt_ff;
   logic [16:0] rsp_seg_sum_ff;
   logic [14:0] rsp_desc_sum_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_cnt_ff      <= cnt_new;
         rsp_seg_sum_ff  <= seg_sum_new;
         rsp_desc_sum_ff <= desc_sum_new;
      end
   end

   assign rsp_if.valid                 = rsp_valid_ff;
   assign rsp_if.seg_bytes             = seg_ff;
   assign rsp_if.zero_bytes            = zero_ff;
   assign rsp_if.zero_space            = space_ff;
   assign rsp_if.segment_count         = rsp_cnt_ff;
   assign rsp_if.total_seg_length      = rsp_seg_sum_ff;
   assign rsp_if.canonical_desc_length = rsp_desc_sum_ff;
   assign rsp_if.truncated             = trunc_ff;
   assign rsp_if.end_of_stream         = eos_ff;

   assert property (@(posedge clock) disable iff (reset)
      pop && head_desc.end_of_stream |=> cnt_ff == 13'd0 && seg_sum_ff == 17'd0)
      else $error("totals not cleared after end of stream");

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SegCountLimit && seg_sum_ff <= SegLenLimit && desc_sum_ff <= DescLenLimit)
      else $error("running total above saturation limit");

   assert property (@(posedge clock) disable iff (reset)
      pop && head_desc.truncated |=> rsp_if.zero_space == 3'd0 && rsp_if.end_of_stream)
      else $error("truncated response with canonical size");

endmodule

// ===== src/bitmap_segment_descriptor_parser.sv =====
// top level of the bitmap segment descriptor parser
//
// req_if takes the descriptor stream one byte per transfer (desc_byte,
// last_byte). rsp_if returns one result per finished descriptor and one for
// the byte that carries last_byte: segment and zero-run lengths, canonical
// extension size, running saturating totals, truncated and end_of_stream.
// csr_wr_en / csr_wr_data write the 4-bit zero-run compact threshold; write it
// only while no transfer is in flight.
// A byte parser sits in front of a two-entry queue, and an accumulator with
// the response register drains it. One byte is taken per cycle while the
// queue is not full; a result reaches rsp_if via a queue entry and the
// response register. The queue and the response register give three results
// of slack: when the receiver stalls, req_if.ready drops once the queue is
// full and rises again as soon as a result moves on. Synchronous reset
// empties the queue, clears all stream state and sets the threshold to 12.
module bitmap_segment_descriptor_parser
   import bsdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   bsdp_req_if.sink    req_if,
   bsdp_rsp_if.source  rsp_if
);

   logic [3:0]       compact_ff;
   logic             push, pop;
   desc_type         push_desc, head_desc;
   queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         compact_ff <= CompactReset;
      end else if (csr_wr_en) begin
         compact_ff <= csr_wr_data;
      end
   end

   bsdp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .compact   (compact_ff),
      .req_if    (req_if),
      .q_status  (q_status),
      .push      (push),
      .push_desc (push_desc)
   );

   bsdp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .q_status  (q_status)
   );

   bsdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .compact   (compact_ff),
      .head_desc (head_desc),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule
